// ===== rtl/vat_pkg.sv =====
// Shared types and constants for the view autorange tracker.
// Used by vat_alu and view_autorange_tracker_core; no dependencies.
package vat_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned HALF_W     = 31;
  localparam int unsigned WIDE_W     = 34;
  localparam int unsigned POS_AXES   = 3;
  localparam int unsigned AXIS_IDX_W = 2;
  localparam int unsigned PADDR_W    = 4;

  localparam logic [HALF_W-1:0] HALF_MAX   = {HALF_W{1'b1}};
  localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(65536);

  // Register indexes on the configuration port
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;
  localparam logic [1:0] REG_HALF     = 2'd3;

  // Operations of the shared add/compare unit
  typedef enum logic [2:0] {
    OP_LO_CHK,   // c - h, flag when p is below it
    OP_HI_CHK,   // c + h, flag when p is above it
    OP_GROW,     // h + max(h >> 1, 1), flag when it reaches the maximum
    OP_SHIFT_LO, // p + (h >> 1), saturated
    OP_SHIFT_HI  // p - (h >> 1), saturated
  } vat_op_e;

  typedef struct packed {
    logic              flag;
    logic [DATA_W-1:0] sat_val;
    logic [HALF_W-1:0] half_val;
  } vat_alu_res_t;

endpackage

// ===== rtl/view_autorange_tracker_core.sv =====
// View autorange tracker: an item is accepted, then per axis the low check runs, then the high
// check when needed, then either a center shift or growth steps, each a grow and a check (a
// step that saturates has no check), and last the result is handed off, held back while the
// output is stalled. One shared 34-bit add and compare unit does every step. Not ready while
// an item runs. Reset (async, active low) loads centers 0, half size 1.0, side bits clear.
// Depends on vat_pkg and vat_alu.
module view_autorange_tracker_core
  import vat_pkg::*;
#(
  parameter int unsigned AXES = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [DATA_W-1:0]    pos_x_i,
  input  logic [DATA_W-1:0]    pos_y_i,
  input  logic [DATA_W-1:0]    pos_z_i,
  input  logic                 restart_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DATA_W-1:0]    view_x_o,
  output logic [DATA_W-1:0]    view_y_o,
  output logic [DATA_W-1:0]    view_z_o,
  output logic [HALF_W-1:0]    view_half_o,
  output logic                 size_saturated_o
);

  localparam int unsigned HANDLED = (AXES < POS_AXES) ? AXES : POS_AXES;
  localparam int unsigned CNT_W   = (HANDLED > 1) ? $clog2(HANDLED) : 1;
  localparam logic [CNT_W-1:0] LAST_AXIS = CNT_W'(HANDLED - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_GROW,
    S_GCHK,
    S_SHIFT,
    S_DONE
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [DATA_W-1:0] cfg_center_q [POS_AXES];
  logic [HALF_W-1:0] cfg_half_q;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write a register on the access beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_center_q[0] <= '0;
      cfg_center_q[1] <= '0;
      cfg_center_q[2] <= '0;
      cfg_half_q      <= HALF_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CENTER_X: cfg_center_q[0] <= pwdata;
        REG_CENTER_Y: cfg_center_q[1] <= pwdata;
        REG_CENTER_Z: cfg_center_q[2] <= pwdata;
        REG_HALF:     cfg_half_q      <= pwdata[HALF_W-1:0];
        default:      cfg_half_q      <= cfg_half_q;
      endcase
    end
  end

  // Return register contents
  always_comb begin
    case (cfg_idx)
      REG_CENTER_X: prdata = cfg_center_q[0];
      REG_CENTER_Y: prdata = cfg_center_q[1];
      REG_CENTER_Z: prdata = cfg_center_q[2];
      REG_HALF:     prdata = {1'b0, cfg_half_q};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer and view state
  state_e            state_q;
  logic [CNT_W-1:0]  axis_q;
  logic              dir_lo_q;
  logic              sat_q;
  logic [DATA_W-1:0] pos_q     [POS_AXES];
  logic [DATA_W-1:0] center_q  [POS_AXES];
  logic [HALF_W-1:0] half_q;
  logic              side_lo_q [POS_AXES];
  logic [DATA_W-1:0] out_center_q [POS_AXES];
  logic [HALF_W-1:0] out_half_q;
  logic              out_sat_q;
  logic              out_valid_q;

  logic [AXIS_IDX_W-1:0] axis_idx;
  vat_op_e               alu_op;
  vat_alu_res_t          alu_res;
  logic                  in_beat;
  logic                  out_free;

  assign axis_idx   = AXIS_IDX_W'(axis_q);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Pick the unit's operation for this step
  always_comb begin
    case (state_q)
      S_LO:    alu_op = OP_LO_CHK;
      S_HI:    alu_op = OP_HI_CHK;
      S_GROW:  alu_op = OP_GROW;
      S_GCHK:  alu_op = dir_lo_q ? OP_LO_CHK : OP_HI_CHK;
      S_SHIFT: alu_op = dir_lo_q ? OP_SHIFT_LO : OP_SHIFT_HI;
      default: alu_op = OP_LO_CHK;
    endcase
  end

  vat_alu u_alu (
    .op_i     (alu_op),
    .pos_i    (pos_q[axis_idx]),
    .center_i (center_q[axis_idx]),
    .half_i   (half_q),
    .res_o    (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      axis_q       <= '0;
      dir_lo_q     <= 1'b0;
      sat_q        <= 1'b0;
      half_q       <= HALF_RESET;
      out_half_q   <= '0;
      out_sat_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < POS_AXES; i++) begin
        center_q[i]     <= '0;
        side_lo_q[i]    <= 1'b0;
        pos_q[i]        <= '0;
        out_center_q[i] <= '0;
      end
    end else begin
      // Drop the result once taken, unless a new one is handed off now
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            pos_q[0] <= pos_x_i;
            pos_q[1] <= pos_y_i;
            pos_q[2] <= pos_z_i;
            axis_q   <= '0;
            sat_q    <= 1'b0;
            state_q  <= S_LO;
            // Reload the view on restart
            if (restart_i) begin
              half_q <= (cfg_half_q == '0) ? HALF_W'(1) : cfg_half_q;
              for (int i = 0; i < POS_AXES; i++) begin
                center_q[i]  <= cfg_center_q[i];
                side_lo_q[i] <= 1'b0;
              end
            end
          end
        end
        S_LO: begin
          if (alu_res.flag) begin
            dir_lo_q            <= 1'b1;
            side_lo_q[axis_idx] <= 1'b1;
            state_q             <= side_lo_q[axis_idx] ? S_SHIFT : S_GROW;
          end else begin
            state_q <= S_HI;
          end
        end
        S_HI: begin
          if (alu_res.flag) begin
            dir_lo_q            <= 1'b0;
            side_lo_q[axis_idx] <= 1'b0;
            state_q             <= side_lo_q[axis_idx] ? S_GROW : S_SHIFT;
          end else if (axis_q == LAST_AXIS) begin
            state_q <= S_DONE;
          end else begin
            axis_q  <= axis_q + CNT_W'(1);
            state_q <= S_LO;
          end
        end
        S_GROW: begin
          half_q <= alu_res.half_val;
          if (alu_res.flag) begin
            // Maximum reached: stop growing this axis
            sat_q <= 1'b1;
            if (axis_q == LAST_AXIS) begin
              state_q <= S_DONE;
            end else begin
              axis_q  <= axis_q + CNT_W'(1);
              state_q <= S_LO;
            end
          end else begin
            state_q <= S_GCHK;
          end
        end
        S_GCHK: begin
          if (alu_res.flag) begin
            state_q <= S_GROW;
          end else if (axis_q == LAST_AXIS) begin
            state_q <= S_DONE;
          end else begin
            axis_q  <= axis_q + CNT_W'(1);
            state_q <= S_LO;
          end
        end
        S_SHIFT: begin
          center_q[axis_idx] <= alu_res.sat_val;
          if (axis_q == LAST_AXIS) begin
            state_q <= S_DONE;
          end else begin
            axis_q  <= axis_q + CNT_W'(1);
            state_q <= S_LO;
          end
        end
        S_DONE: begin
          // Hand off once the output register is free
          if (out_free) begin
            for (int i = 0; i < POS_AXES; i++) begin
              out_center_q[i] <= center_q[i];
            end
            out_half_q  <= half_q;
            out_sat_q   <= sat_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign view_x_o         = out_center_q[0];
  assign view_y_o         = out_center_q[1];
  assign view_z_o         = out_center_q[2];
  assign view_half_o      = out_half_q;
  assign size_saturated_o = out_sat_q;

endmodule

// ===== rtl/vat_alu.sv =====
// Shared 34-bit add/subtract and compare unit of the view autorange tracker.
// Depends on vat_pkg for the operation codes and the result struct.
module vat_alu
  import vat_pkg::*;
(
  input  vat_op_e             op_i,
  input  logic [DATA_W-1:0]   pos_i,
  input  logic [DATA_W-1:0]   center_i,
  input  logic [HALF_W-1:0]   half_i,
  output vat_alu_res_t        res_o
);

  logic signed [WIDE_W-1:0] pos_w;
  logic signed [WIDE_W-1:0] center_w;
  logic signed [WIDE_W-1:0] half_w;
  logic signed [WIDE_W-1:0] hh_w;
  logic signed [WIDE_W-1:0] step_w;
  logic signed [WIDE_W-1:0] opa;
  logic signed [WIDE_W-1:0] opb;
  logic                     sub;
  logic signed [WIDE_W-1:0] sum;
  logic                     ovf;
  logic                     flag;
  logic [DATA_W-1:0]        sat_val;
  logic [HALF_W-1:0]        half_val;

  // Widen operands
  assign pos_w    = WIDE_W'($signed(pos_i));
  assign center_w = WIDE_W'($signed(center_i));
  assign half_w   = $signed({{(WIDE_W-HALF_W){1'b0}}, half_i});
  assign hh_w     = half_w >>> 1;
  assign step_w   = (hh_w == '0) ? WIDE_W'(1) : hh_w;

  // Select operands
  always_comb begin
    opa = center_w;
    opb = half_w;
    sub = 1'b0;
    case (op_i)
      OP_LO_CHK: begin
        opa = center_w;
        opb = half_w;
        sub = 1'b1;
      end
      OP_HI_CHK: begin
        opa = center_w;
        opb = half_w;
        sub = 1'b0;
      end
      OP_GROW: begin
        opa = half_w;
        opb = step_w;
        sub = 1'b0;
      end
      OP_SHIFT_LO: begin
        opa = pos_w;
        opb = hh_w;
        sub = 1'b0;
      end
      OP_SHIFT_HI: begin
        opa = pos_w;
        opb = hh_w;
        sub = 1'b1;
      end
      default: begin
        opa = center_w;
        opb = half_w;
        sub = 1'b0;
      end
    endcase
  end

  assign sum = sub ? (opa - opb) : (opa + opb);

  // Compare against the position or the half size maximum
  always_comb begin
    case (op_i)
      OP_LO_CHK: flag = (pos_w < sum);
      OP_HI_CHK: flag = (pos_w > sum);
      OP_GROW:   flag = (sum >= $signed({{(WIDE_W-HALF_W){1'b0}}, HALF_MAX}));
      default:   flag = 1'b0;
    endcase
  end

  // Saturate to the signed 32-bit range
  assign ovf = (sum[WIDE_W-1:DATA_W-1] != {(WIDE_W-DATA_W+1){1'b0}}) &&
               (sum[WIDE_W-1:DATA_W-1] != {(WIDE_W-DATA_W+1){1'b1}});

  always_comb begin
    if (!ovf) begin
      sat_val = sum[DATA_W-1:0];
    end else if (sum[WIDE_W-1]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // Clamp grown half size
  assign half_val = flag ? HALF_MAX : sum[HALF_W-1:0];

  assign res_o = '{flag: flag, sat_val: sat_val, half_val: half_val};

endmodule
